[hw/rtl/feedback_fractional_delay_top_macros.svh]
// ----------------------------------------------------------------------------
// feedback fractional delay assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_FRACTIONAL_DELAY_TOP_MACROS_SVH
`define FEEDBACK_FRACTIONAL_DELAY_TOP_MACROS_SVH

// check that is switched off while reset is high
`define FDL_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fdl: property violated");

// check that also holds during reset
`define FDL_ASSERT(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("fdl: property violated");

`endif

[hw/rtl/fdl_pkg.sv]
// ----------------------------------------------------------------------------
// fdl_pkg
// Types, constants and codes shared by the feedback fractional delay block.
// ----------------------------------------------------------------------------
package fdl_pkg;

   // default sizes
   localparam int DEF_BUFFER_DEPTH = 131072;
   localparam int DEF_CHANNELS     = 2;

   // field widths
   localparam int SAMPLE_W = 24;
   localparam int DWHOLE_W = 17;
   localparam int DFRAC_W  = 8;
   localparam int FB_W     = 16;
   localparam int MIX_W    = 17;

   // register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register reset values and limits
   localparam logic [DWHOLE_W-1:0] DWHOLE_RST = 17'd12000;
   localparam logic [DFRAC_W-1:0]  DFRAC_RST  = 8'd0;
   localparam logic [FB_W-1:0]     FB_RST     = 16'd19661;
   localparam logic [MIX_W-1:0]    MIX_RST    = 17'd32768;
   localparam logic [FB_W-1:0]     FB_MAX     = 16'd62259;
   localparam logic [MIX_W-1:0]    MIX_ONE    = 17'd65536;

   // shared multiply-accumulate unit
   localparam int MAC_A_W = 32;
   localparam int MAC_B_W = 18;
   localparam int MAC_P_W = MAC_A_W + MAC_B_W;

   // register indexes
   typedef enum logic [1:0] {
      REG_DELAY_WHOLE = 2'd0,
      REG_DELAY_FRAC  = 2'd1,
      REG_FEEDBACK    = 2'd2,
      REG_MIX         = 2'd3
   } reg_index_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [DWHOLE_W-1:0] delay_whole;
      logic [DFRAC_W-1:0]  delay_frac;
      logic [FB_W-1:0]     feedback_gain;
      logic [MIX_W-1:0]    mix_gain;
   } cfg_type;

   // control of the multiply-accumulate unit
   typedef struct packed {
      logic issue;
      logic clear;
   } mac_ctrl_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADDR,
      ST_RD1,
      ST_RD2,
      ST_MAC1,
      ST_MAC2,
      ST_MAC3,
      ST_MAC4,
      ST_MAC5,
      ST_DONE
   } seq_state_type;

endpackage

[hw/rtl/fdl_csr.sv]
// ----------------------------------------------------------------------------
// fdl_csr
// Configuration registers behind a simple peripheral bus port.
// ----------------------------------------------------------------------------
module fdl_csr
   import fdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[3:2]);

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_DELAY_WHOLE: cfg_in.delay_whole   = pwdata[DWHOLE_W-1:0];
            REG_DELAY_FRAC:  cfg_in.delay_frac    = pwdata[DFRAC_W-1:0];
            REG_FEEDBACK:    cfg_in.feedback_gain = pwdata[FB_W-1:0];
            REG_MIX:         cfg_in.mix_gain      = pwdata[MIX_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_whole   <= DWHOLE_RST;
         cfg_ff.delay_frac    <= DFRAC_RST;
         cfg_ff.feedback_gain <= FB_RST;
         cfg_ff.mix_gain      <= MIX_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read back
   always_comb begin
      case (idx)
         REG_DELAY_WHOLE: prdata = CSR_DATA_W'(cfg_ff.delay_whole);
         REG_DELAY_FRAC:  prdata = CSR_DATA_W'(cfg_ff.delay_frac);
         REG_FEEDBACK:    prdata = CSR_DATA_W'(cfg_ff.feedback_gain);
         REG_MIX:         prdata = CSR_DATA_W'(cfg_ff.mix_gain);
         default:         prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[hw/rtl/fdl_store.sv]
// ----------------------------------------------------------------------------
// fdl_store
// Delay line memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fdl_store
   import fdl_pkg::*;
#(
   parameter int DEPTH  = DEF_CHANNELS * DEF_BUFFER_DEPTH,
   parameter int ADDR_W = $clog2(DEPTH)
)
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] store_ff [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/fdl_mac.sv]
// ----------------------------------------------------------------------------
// fdl_mac
// Shared signed 32x18 multiplier with a registered product and accumulator.
// ----------------------------------------------------------------------------
module fdl_mac
   import fdl_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctrl_type               ctrl,
   input  logic signed [MAC_A_W-1:0]  op_a,
   input  logic signed [MAC_B_W-1:0]  op_b,
   output logic signed [MAC_P_W-1:0]  acc
);

   logic signed [MAC_P_W-1:0] prod_ff;
   logic signed [MAC_P_W-1:0] prod_in;
   logic signed [MAC_P_W-1:0] acc_ff;
   logic signed [MAC_P_W-1:0] acc_in;
   logic                      prod_valid_ff;
   logic                      clear_ff;

   // multiply stage
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         clear_ff      <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.issue;
         clear_ff      <= ctrl.clear;
      end
   end

   // accumulate stage
   always_comb begin
      acc_in = acc_ff;
      if (prod_valid_ff) begin
         acc_in = (clear_ff ? '0 : acc_ff) + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[hw/rtl/feedback_fractional_delay_top.sv]
// ----------------------------------------------------------------------------
// feedback_fractional_delay_top
// Per-channel feedback echo with a linearly interpolated fractional delay.
// Each sample passes through the sequencer states in order: ST_IDLE, in which
// it is accepted; ST_ADDR, which forms the read point; ST_RD1 and ST_RD2,
// which read on the single delay memory port; ST_MAC1 to ST_MAC5, while the
// one shared 32x18 multiply-accumulate unit works through its five products
// (the first one is issued in ST_RD2); and ST_DONE, which writes back and
// loads the result into the output register. The sequencer holds in the
// write back state while the previous result still waits on rsp. The input is
// ready only in the idle state. The delay store starts as all zero without a
// clearing pass: a per-channel wrap flag and the write position mark which
// entries have been written, and an unwritten entry reads as zero. The user
// must write configuration while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module feedback_fractional_delay_top
   import fdl_pkg::*;
#(
   parameter int BUFFER_DEPTH = DEF_BUFFER_DEPTH,
   parameter int CHANNELS     = DEF_CHANNELS
)
(
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [23:0] in_sample
   input  logic [0:0]            req_tuser,   // [0] chan
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SAMPLE_W-1:0]   rsp_tdata,   // [23:0] out_sample
   output logic [0:0]            rsp_tuser,   // [0] out_chan
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int IDX_W  = $clog2(BUFFER_DEPTH);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W = $clog2(CHANNELS * BUFFER_DEPTH);
   localparam int CMP_W  = (IDX_W > DWHOLE_W) ? IDX_W + 1 : DWHOLE_W + 1;
   localparam int RND_W  = MAC_P_W - 24;
   localparam int SAT_W  = RND_W + 1;

   // saturate to a signed 24-bit sample
   function automatic logic [SAMPLE_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
      logic [SAMPLE_W-1:0] r;
      if (v > SAT_W'(signed'(24'sh7FFFFF))) begin
         r = 24'h7FFFFF;
      end else if (v < SAT_W'(signed'(24'sh800000))) begin
         r = 24'h800000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   cfg_type cfg;

   seq_state_type state_ff;
   seq_state_type state_in;

   // per-channel write position and wrap flag
   logic [IDX_W-1:0] wp_ff   [CHANNELS];
   logic             full_ff [CHANNELS];

   // item registers
   logic [CH_W-1:0]            ch_ff,       ch_in;
   logic                       chan_ff,     chan_in;
   logic signed [SAMPLE_W-1:0] x_ff,        x_in;
   logic [ADDR_W-1:0]          base_ff,     base_in;
   logic [IDX_W-1:0]           wpos_ff,     wpos_in;
   logic                       full_cur_ff, full_cur_in;
   logic [IDX_W-1:0]           i1_ff,       i1_in;
   logic [IDX_W-1:0]           i2_ff,       i2_in;
   logic [DFRAC_W-1:0]         f_ff,        f_in;
   logic                       v1_ff,       v1_in;
   logic                       v2_ff,       v2_in;
   logic signed [MAC_A_W-1:0]  dq_ff,       dq_in;
   logic [SAMPLE_W-1:0]        y_ff,        y_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_chan_ff, rsp_chan_in;

   // datapath signals
   logic                      req_accept;
   logic                      out_free;
   logic                      store_we;
   logic                      rd_second;
   logic [ADDR_W-1:0]         rd_addr;
   logic [ADDR_W-1:0]         wr_addr;
   logic [SAMPLE_W-1:0]       rd_data;
   logic [SAMPLE_W-1:0]       s_masked;
   logic [SAMPLE_W-1:0]       st_value;
   mac_ctrl_type              mac_ctrl;
   logic signed [MAC_A_W-1:0] op_a;
   logic signed [MAC_B_W-1:0] op_b;
   logic signed [MAC_P_W-1:0] acc;
   logic signed [MAC_P_W-1:0] acc_rnd;
   logic signed [RND_W-1:0]   rnd_val;
   logic                      clamp;
   logic [IDX_W-1:0]          dw_c;
   logic [DFRAC_W-1:0]        df_c;
   logic [IDX_W+1:0]          diff_c;
   logic [IDX_W+1:0]          wrap_c;
   logic [FB_W-1:0]           fb_c;
   logic [MIX_W-1:0]          mix_c;
   logic [IDX_W-1:0]          wpos_next;
   logic                      wpos_wrap;

   // configuration registers
   fdl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // delay memory for all channels
   fdl_store #(
      .DEPTH  (CHANNELS * BUFFER_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (wr_addr),
      .wr_data (st_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared multiply-accumulate unit
   fdl_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_ADDR;
         ST_ADDR: state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_MAC1;
         ST_MAC1: state_in = ST_MAC2;
         ST_MAC2: state_in = ST_MAC3;
         ST_MAC3: state_in = ST_MAC4;
         ST_MAC4: state_in = ST_MAC5;
         ST_MAC5: state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // clamped gains
   assign fb_c  = (cfg.feedback_gain > FB_MAX) ? FB_MAX : cfg.feedback_gain;
   assign mix_c = (cfg.mix_gain > MIX_ONE) ? MIX_ONE : cfg.mix_gain;

   // unwritten entries read as zero
   assign s_masked = ((rd_second ? v2_ff : v1_ff)) ? rd_data : '0;

   // sequencer outputs
   always_comb begin
      req_tready     = 1'b0;
      store_we       = 1'b0;
      rd_second      = 1'b1;
      mac_ctrl.issue = 1'b0;
      mac_ctrl.clear = 1'b0;
      op_a           = '0;
      op_b           = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
         end
         ST_RD1: begin
            rd_second = 1'b0;
         end
         ST_RD2: begin
            // older neighbor times (1 - frac)
            rd_second      = 1'b0;
            mac_ctrl.issue = 1'b1;
            mac_ctrl.clear = 1'b1;
            op_a           = MAC_A_W'(signed'(s_masked));
            op_b           = MAC_B_W'(9'd256) - MAC_B_W'(f_ff);
         end
         ST_MAC1: begin
            // newer neighbor times frac
            mac_ctrl.issue = 1'b1;
            op_a           = MAC_A_W'(signed'(s_masked));
            op_b           = MAC_B_W'(f_ff);
         end
         ST_MAC2: begin
            // dry part, sample scaled by 256
            mac_ctrl.issue = 1'b1;
            mac_ctrl.clear = 1'b1;
            op_a           = {x_ff, 8'b0};
            op_b           = MAC_B_W'(MIX_ONE) - MAC_B_W'(mix_c);
         end
         ST_MAC3: begin
            // wet part, delayed value straight from the accumulator
            mac_ctrl.issue = 1'b1;
            op_a           = acc[MAC_A_W-1:0];
            op_b           = MAC_B_W'(mix_c);
         end
         ST_MAC4: begin
            // feedback term
            mac_ctrl.issue = 1'b1;
            mac_ctrl.clear = 1'b1;
            op_a           = dq_ff;
            op_b           = MAC_B_W'(fb_c);
         end
         ST_DONE: begin
            store_we = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // read point from the write position and the clamped delay
   always_comb begin
      clamp  = ({{(CMP_W-DWHOLE_W){1'b0}}, cfg.delay_whole} >= CMP_W'(BUFFER_DEPTH - 1));
      dw_c   = clamp ? IDX_W'(BUFFER_DEPTH - 1) : IDX_W'(cfg.delay_whole);
      df_c   = clamp ? '0 : cfg.delay_frac;
      diff_c = {2'b00, wp_ff[ch_ff]} - {2'b00, dw_c} - (IDX_W+2)'(df_c != '0);
      wrap_c = diff_c + (IDX_W+2)'(BUFFER_DEPTH);
   end

   // rounding of the accumulator, half up
   assign acc_rnd = acc + MAC_P_W'(25'sd8388608);
   assign rnd_val = acc_rnd[MAC_P_W-1:24];

   // stored value: input plus feedback term
   assign st_value = sat24(SAT_W'(x_ff) + SAT_W'(rnd_val));

   // memory addresses: older neighbor in the first read cycle, newer one after
   assign rd_addr = base_ff + ADDR_W'((state_ff == ST_RD1) ? i1_ff : i2_ff);
   assign wr_addr = base_ff + ADDR_W'(wpos_ff);

   // write position advance
   assign wpos_wrap = (wpos_ff == IDX_W'(BUFFER_DEPTH - 1));
   assign wpos_next = wpos_wrap ? '0 : wpos_ff + 1'b1;

   // item register next values
   always_comb begin
      ch_in       = ch_ff;
      chan_in     = chan_ff;
      x_in        = x_ff;
      base_in     = base_ff;
      wpos_in     = wpos_ff;
      full_cur_in = full_cur_ff;
      i1_in       = i1_ff;
      i2_in       = i2_ff;
      f_in        = f_ff;
      v1_in       = v1_ff;
      v2_in       = v2_ff;
      dq_in       = dq_ff;
      y_in        = y_ff;
      if (req_accept) begin
         chan_in = req_tuser[0];
         ch_in   = (CHANNELS > 1) ? CH_W'(req_tuser[0]) : '0;
         x_in    = req_tdata;
         base_in = ((CHANNELS > 1) ? ADDR_W'(req_tuser[0]) : '0) * ADDR_W'(BUFFER_DEPTH);
      end
      case (state_ff)
         ST_ADDR: begin
            wpos_in     = wp_ff[ch_ff];
            full_cur_in = full_ff[ch_ff];
            i1_in       = diff_c[IDX_W+1] ? wrap_c[IDX_W-1:0] : diff_c[IDX_W-1:0];
            f_in        = 8'd0 - df_c;
         end
         ST_RD1: begin
            i2_in = (i1_ff == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : i1_ff + 1'b1;
            v1_in = full_cur_ff || (i1_ff < wpos_ff);
         end
         ST_RD2: begin
            v2_in = full_cur_ff || (i2_ff < wpos_ff);
         end
         ST_MAC3: begin
            dq_in = acc[MAC_A_W-1:0];
         end
         ST_MAC5: begin
            y_in = sat24(SAT_W'(rnd_val));
         end
         default: begin
            dq_in = dq_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      chan_ff     <= chan_in;
      x_ff        <= x_in;
      base_ff     <= base_in;
      wpos_ff     <= wpos_in;
      full_cur_ff <= full_cur_in;
      i1_ff       <= i1_in;
      i2_ff       <= i2_in;
      f_ff        <= f_in;
      v1_ff       <= v1_in;
      v2_ff       <= v2_in;
      dq_ff       <= dq_in;
      y_ff        <= y_in;
   end

   // write positions and wrap flags
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            wp_ff[c]   <= '0;
            full_ff[c] <= 1'b0;
         end
      end else if (store_we) begin
         wp_ff[ch_ff]   <= wpos_next;
         full_ff[ch_ff] <= full_cur_ff || wpos_wrap;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_chan_in   = rsp_chan_ff;
      if (store_we) begin
         rsp_valid_in  = 1'b1;
         rsp_sample_in = y_ff;
         rsp_chan_in   = chan_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_sample_ff <= rsp_sample_in;
      rsp_chan_ff   <= rsp_chan_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_sample_ff;
   assign rsp_tuser[0] = rsp_chan_ff;

endmodule

[hw/rtl/fdl_checker.sv]
// ----------------------------------------------------------------------------
// fdl_checker
// Port-level checks of the feedback fractional delay block, bound to the top.
// ----------------------------------------------------------------------------
`include "feedback_fractional_delay_top_macros.svh"

module fdl_checker
   import fdl_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [SAMPLE_W-1:0] rsp_tdata,
   input logic [0:0]          rsp_tuser,
   input logic                csr_pready
);

   // one sample at a time: ready drops after a transaction
   `FDL_ASSERT_RST(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready ##1 !req_tready)

   // a stalled result holds its value
   `FDL_ASSERT_RST(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // reset drops any pending result
   `FDL_ASSERT(a_reset_empty, clock, reset |=> !rsp_tvalid)

   // register port never waits
   `FDL_ASSERT(a_pready_high, clock, csr_pready)

endmodule

bind feedback_fractional_delay_top fdl_checker u_fdl_checker (.*);

[dv/fdl_echo_checker.sv]
// ----------------------------------------------------------------------------
// fdl_echo_checker
// Watches the sample streams and the register port of the feedback delay
// block, keeps its own delay stores, write positions and settings, predicts
// each mixed output sample and compares it with the oldest one still due.
// ----------------------------------------------------------------------------
module fdl_echo_checker
   import fdl_pkg::*;
#(
   parameter int DEPTH = DEF_BUFFER_DEPTH
)
(
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [SAMPLE_W-1:0]   req_tdata,   // [23:0] in_sample
   input  logic [0:0]            req_tuser,   // [0] chan
   // result stream
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [SAMPLE_W-1:0]   rsp_tdata,   // [23:0] out_sample
   input  logic [0:0]            rsp_tuser,   // [0] out_chan
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   // status to the top
   output int                    mismatches,
   output int                    in_flight
);

   typedef struct packed {
      logic                       chan;
      logic signed [SAMPLE_W-1:0] sample;
   } echo_out_type;

   // shadow of the delay stores, write positions and settings
   logic signed [SAMPLE_W-1:0] echo_mem [DEF_CHANNELS][DEPTH];
   int                         wr_pos [DEF_CHANNELS];
   logic [DWHOLE_W-1:0]        cfg_whole;
   logic [DFRAC_W-1:0]         cfg_frac;
   logic [FB_W-1:0]            cfg_fb;
   logic [MIX_W-1:0]           cfg_mix;
   echo_out_type               due_outputs [$];

   // saturate to the 24-bit sample range
   function automatic logic signed [SAMPLE_W-1:0] clip24(longint v);
      if (v > 64'sd8388607) return 24'sh7FFFFF;
      if (v < -64'sd8388608) return 24'sh800000;
      return v[SAMPLE_W-1:0];
   endfunction

   // stores start out cleared
   initial begin
      foreach (echo_mem[c, i]) echo_mem[c][i] = '0;
   end

   always @(posedge clock) begin : track_echo
      echo_out_type got;
      echo_out_type want;
      int           ch;
      longint       x, wp, dw, df, fb, mx, rd_pt, i1, i2, ph, tap, fbk, acc;
      if (reset) begin
         foreach (wr_pos[c]) wr_pos[c] = 0;
         cfg_whole = DWHOLE_RST;
         cfg_frac  = DFRAC_RST;
         cfg_fb    = FB_RST;
         cfg_mix   = MIX_RST;
         due_outputs.delete();
         in_flight = 0;
      end else begin
         // result transaction against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.chan   = rsp_tuser[0];
            got.sample = rsp_tdata;
            if (due_outputs.size() == 0) begin
               $error("unexpected result: out_chan %0d out_sample %0d", got.chan, got.sample);
               mismatches++;
            end else begin
               want = due_outputs.pop_front();
               if (got.chan !== want.chan) begin
                  $error("out_chan mismatch: expected %0d, actual %0d", want.chan, got.chan);
                  mismatches++;
               end
               if (got.sample !== want.sample) begin
                  $error("out_sample mismatch: expected %0d, actual %0d",
                         want.sample, got.sample);
                  mismatches++;
               end
            end
         end

         // register write transaction
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_DELAY_WHOLE: cfg_whole = csr_pwdata[DWHOLE_W-1:0];
               REG_DELAY_FRAC:  cfg_frac  = csr_pwdata[DFRAC_W-1:0];
               REG_FEEDBACK:    cfg_fb    = csr_pwdata[FB_W-1:0];
               REG_MIX:         cfg_mix   = csr_pwdata[MIX_W-1:0];
               default: ;
            endcase
         end

         // input transaction: interpolate the echo, write back, mix
         if (req_tvalid && req_tready) begin
            ch = int'(req_tuser[0]) % DEF_CHANNELS;
            x  = longint'(signed'(req_tdata));
            wp = wr_pos[ch];
            dw = cfg_whole;
            df = cfg_frac;
            // delay longer than the store: pin to the end, no fraction
            if (dw >= DEPTH - 1) begin
               dw = DEPTH - 1;
               df = 0;
            end
            fb = (cfg_fb > FB_MAX) ? longint'(FB_MAX) : longint'(cfg_fb);
            mx = (cfg_mix > MIX_ONE) ? longint'(MIX_ONE) : longint'(cfg_mix);

            // read point in 1/256 sample, wrapped into the store
            rd_pt = wp * 256 - (dw * 256 + df);
            if (rd_pt < 0) rd_pt = rd_pt + longint'(DEPTH) * 256;
            i1  = (rd_pt >> 8) % DEPTH;
            ph  = rd_pt % 256;
            i2  = (i1 + 1) % DEPTH;
            tap = longint'(echo_mem[ch][i1]) * (256 - ph) + longint'(echo_mem[ch][i2]) * ph;

            // zero delay reads the old entry before this write
            fbk = (tap * fb + 64'sd8388608) >>> 24;
            echo_mem[ch][wp] = clip24(x + fbk);

            acc = x * (longint'(MIX_ONE) - mx) * 256 + tap * mx;
            want.chan   = req_tuser[0];
            want.sample = clip24((acc + 64'sd8388608) >>> 24);
            due_outputs.push_back(want);
            wr_pos[ch] = int'((wp + 1) % DEPTH);
         end
         in_flight = due_outputs.size();
      end
   end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives sample transactions and register writes into the feedback delay
// block: a directed opening over delay, feedback and mix extremes, then
// random samples under changing settings and idling patterns on both
// streams. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench
   import fdl_pkg::*;
;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata   = '0;   // [23:0] in_sample
   logic [0:0]            req_tuser   = '0;   // [0] chan
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_tdata;          // [23:0] out_sample
   logic [0:0]            rsp_tuser;          // [0] out_chan
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    mismatches;
   int                    in_flight;
   int                    tx_idle_pct = 0;
   int                    rx_idle_pct = 0;

   feedback_fractional_delay_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fdl_echo_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (mismatches),
      .in_flight   (in_flight)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #3000000;
      $display("feedback_fractional_delay_top regression: fail");
      $finish;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // register write: setup cycle, then access until pready
   task automatic csr_write(reg_index_type which, logic [CSR_DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'({which, 2'b00});
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      while (!csr_pready) @(negedge clock);
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_echo(int unsigned whole, int unsigned frac, int unsigned fb,
                           int unsigned mix);
      csr_write(REG_DELAY_WHOLE, CSR_DATA_W'(whole));
      csr_write(REG_DELAY_FRAC, CSR_DATA_W'(frac));
      csr_write(REG_FEEDBACK, CSR_DATA_W'(fb));
      csr_write(REG_MIX, CSR_DATA_W'(mix));
   endtask

   // one sample transaction, returns at the accepting edge with valid still high
   task automatic push_sample(logic ch, logic [SAMPLE_W-1:0] smp);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= ch;
      req_tdata  <= smp;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
   endtask

   // wait until every result is in, plus the block's own latency
   task automatic settle();
      @(negedge clock);
      while (in_flight != 0) @(negedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return SAMPLE_W'($urandom_range(15));
         3: return ~SAMPLE_W'($urandom_range(15));
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // random settings, biased toward short delays so echoes show up
   task automatic random_settings();
      int unsigned whole, fb, mix;
      case ($urandom_range(9))
         0: whole = 17'h1FFFF;
         1: whole = DEF_BUFFER_DEPTH - 1 - $urandom_range(1);
         2: whole = $urandom_range(131071);
         default: whole = $urandom_range(40);
      endcase
      case ($urandom_range(5))
         0: fb = $urandom_range(65535, 62260);
         1: fb = FB_MAX;
         default: fb = $urandom_range(62259);
      endcase
      case ($urandom_range(7))
         0: mix = 0;
         1: mix = MIX_ONE;
         2: mix = $urandom_range(131071, 65537);
         default: mix = $urandom_range(65536);
      endcase
      set_echo(whole, $urandom_range(255), fb, mix);
   endtask

   initial begin : stimulus
      int seg;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, full scale and tiny values on both channels
      push_sample(1'b0, 24'h7FFFFF);
      push_sample(1'b1, 24'h800000);
      push_sample(1'b0, 24'h000000);
      push_sample(1'b1, 24'hFFFFFF);
      req_tvalid <= 1'b0;
      settle();

      // zero delay, strongest feedback, fully wet
      set_echo(0, 0, FB_MAX, MIX_ONE);
      push_sample(1'b0, 24'h7FFFFF);
      push_sample(1'b0, 24'h800000);
      push_sample(1'b1, 24'h000001);
      push_sample(1'b1, 24'h7FFFFF);
      req_tvalid <= 1'b0;
      settle();

      // one and a half samples, feedback and mix written above range
      set_echo(1, 128, 16'hFFFF, 17'h1FFFF);
      repeat (6) push_sample(1'b0, 24'h7FFFFF);
      push_sample(1'b1, 24'h800000);
      req_tvalid <= 1'b0;
      settle();

      // delay beyond the store with fraction ignored, dry only
      set_echo(17'h1FFFF, 8'hFF, 0, 0);
      push_sample(1'b0, 24'h800000);
      push_sample(1'b1, 24'h7FFFFF);
      push_sample(1'b0, 24'h123456);
      req_tvalid <= 1'b0;
      settle();

      // longest delay that keeps its fraction, wraps past the store end
      set_echo(DEF_BUFFER_DEPTH - 2, 255, 31000, 40000);
      push_sample(1'b1, 24'hABCDEF);
      push_sample(1'b0, 24'h654321);
      push_sample(1'b1, 24'h800000);
      req_tvalid <= 1'b0;
      settle();

      // random part under three idling patterns
      for (seg = 0; seg < 6; seg++) begin
         tx_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 52 : 0;
         rx_idle_pct = (seg < 2) ? 52 : (seg < 4) ? 35 : 0;
         random_settings();
         for (n = 0; n < 222; n++) begin
            // hold the sender until the block has drained, then new settings
            if (n == 111) begin
               req_tvalid <= 1'b0;
               settle();
               random_settings();
            end
            push_sample(1'($urandom_range(1)), pick_sample());
         end
         req_tvalid <= 1'b0;
         settle();
      end

      @(negedge clock);
      if (mismatches == 0 && in_flight == 0) begin
         $display("feedback_fractional_delay_top regression: pass");
      end else begin
         $display("feedback_fractional_delay_top regression: fail");
      end
      $finish;
   end

endmodule
